@@ hw/rtl/mkip_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mkip_pkg: shared types and constants of the ML-KEM NTT inner product unit
// Coefficient widths, Barrett reduction constants, the gamma twiddle table,
// payload structs and the control struct passed to the accumulator stage.
// ----------------------------------------------------------------------------
package mkip_pkg;

    // Field widths
    localparam int COEF_W     = 12;
    localparam int PAIR_W     = 7;
    localparam int POLY_W     = 2;
    localparam int CFG_W      = 3;
    localparam int HALF_W     = 14;
    localparam int ACC_W      = 2 * HALF_W;

    // Defaults for the top-level parameters and the register reset value
    localparam int PAIR_COUNT_DEF   = 128;
    localparam int MAX_POLYS_DEF    = 4;
    localparam int POLY_COUNT_RESET = 3;

    // Modulus and two-step Barrett constants
    localparam int MOD_Q     = 3329;
    localparam int BAR_M1    = 78;
    localparam int BAR_S1    = 18;
    localparam int BAR_M2    = 5039;
    localparam int BAR_S2    = 24;
    localparam int BAR_IN_W  = 25;
    localparam int BAR_P1_W  = 32;
    localparam int BAR_T1_W  = BAR_P1_W - BAR_S1;
    localparam int BAR_X1_W  = 19;
    localparam int BAR_P2_W  = 32;
    localparam int BAR_T2_W  = BAR_P2_W - BAR_S2;
    localparam int PROD_W    = 2 * COEF_W;

    // Output queue sizing: room for every owed result, so a push never overflows
    localparam int OUT_FIFO_DEPTH = 16;
    localparam int FIFO_PTR_W     = $clog2(OUT_FIFO_DEPTH);
    localparam int FIFO_CNT_W     = FIFO_PTR_W + 1;

    // Gamma table: 17^(2*BitRev7(i)+1) mod q for every 7-bit pair index
    localparam int GAMMA_ENTRIES = 1 << PAIR_W;
    typedef logic [GAMMA_ENTRIES-1:0][COEF_W-1:0] t_gamma_tab;

    function automatic t_gamma_tab build_gamma_tab();
        t_gamma_tab  tab;
        int unsigned rev;
        int unsigned e;
        int unsigned r;
        int          idx;
        int          b;
        int unsigned i;
        for (idx = 0; idx < GAMMA_ENTRIES; idx++) begin
            rev = 0;
            for (b = 0; b < PAIR_W; b++) begin
                rev = rev | (((idx >> b) & 1) << (PAIR_W - 1 - b));
            end
            e = 2 * rev + 1;
            r = 1;
            for (i = 0; i < e; i++) begin
                r = (r * 17) % MOD_Q;
            end
            tab[idx] = COEF_W'(r);
        end
        return tab;
    endfunction

    localparam t_gamma_tab GAMMA_TAB = build_gamma_tab();

    // Input item payload
    typedef struct packed {
        logic [COEF_W-1:0] s_even;
        logic [COEF_W-1:0] s_odd;
        logic [COEF_W-1:0] u_even;
        logic [COEF_W-1:0] u_odd;
        logic [PAIR_W-1:0] pair_index;
        logic [POLY_W-1:0] poly_index;
    } t_in_item;

    // Result item payload
    typedef struct packed {
        logic [COEF_W-1:0] w_even;
        logic [COEF_W-1:0] w_odd;
        logic [PAIR_W-1:0] out_pair_index;
        logic              last_pair;
    } t_out_item;

    // Control traveling with each item down the pipeline
    typedef struct packed {
        logic              valid;
        logic              first;
        logic              emit;
        logic [PAIR_W-1:0] pair;
    } t_acc_ctl;

endpackage
`default_nettype wire

@@ hw/rtl/mlkem_ntt_inner_product_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mlkem_ntt_inner_product_unit: ML-KEM NTT-domain vector inner product
// Multiplies coefficient pairs with the gamma twiddle, accumulates per pair and
// emits the reduced sum on the last polynomial of the vector.
// ----------------------------------------------------------------------------
// One coefficient pair is taken per cycle while o_in_ready is high. A result
// leaves on the output channel after a product stage, two chained
// four-stage Barrett reductions around the gamma multiply, and the accumulator
// read-modify-write plus final reduction. Only items of the last polynomial
// (poly_index == clamped poly_count-1) produce a result; items with an out-of-range
// polynomial or pair index are dropped. Results wait in a 16-entry queue;
// o_in_ready falls only while 16 results are owed to the output side and not
// yet taken. Write poly_count only while no items are in flight. Every pair
// must be written by polynomial 0 before later polynomials add to it.
// ----------------------------------------------------------------------------
module mlkem_ntt_inner_product_unit #(
    parameter int PAIR_COUNT = mkip_pkg::PAIR_COUNT_DEF,
    parameter int MAX_POLYS  = mkip_pkg::MAX_POLYS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [mkip_pkg::CFG_W-1:0] i_cfg_wdata,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire mkip_pkg::t_in_item         i_in_data,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output mkip_pkg::t_out_item             o_out_data
);
    import mkip_pkg::*;

    localparam int DLY = 4;

    // Configuration and credit state
    logic [CFG_W-1:0]      r_poly_count;
    logic [FIFO_CNT_W-1:0] r_used;

    // Stage 1: taken item
    t_acc_ctl          r_s1_ctl;
    t_in_item          r_s1_item;

    // Stage 2: raw products and gamma
    t_acc_ctl          r_s2_ctl;
    logic [PROD_W-1:0] r_s2_a1b1;
    logic [PROD_W-1:0] r_s2_a0b0;
    logic [BAR_IN_W-1:0] r_s2_cross;
    logic [COEF_W-1:0] r_s2_gamma;

    // Stages 3..6: alongside the first Barrett pair
    t_acc_ctl          r_d1_ctl   [DLY];
    logic [PROD_W-1:0] r_d1_a0b0  [DLY];
    logic [COEF_W-1:0] r_d1_gamma [DLY];

    // Stage 7: gamma product
    t_acc_ctl          r_s7_ctl;
    logic [PROD_W-1:0] r_s7_m;
    logic [PROD_W-1:0] r_s7_a0b0;
    logic [COEF_W-1:0] r_s7_po;

    // Stages 8..11: alongside the second Barrett
    t_acc_ctl          r_d2_ctl [DLY];
    logic [COEF_W-1:0] r_d2_po  [DLY];

    logic [CFG_W-1:0]    k_eff;
    logic                in_range;
    logic                in_emit;
    logic                in_accept;
    logic                in_prod;
    logic                out_xfer;
    t_acc_ctl            n_s1_ctl;
    logic [COEF_W-1:0]   a1b1_red;
    logic [COEF_W-1:0]   po_red;
    logic [COEF_W-1:0]   pe_red;
    logic [BAR_IN_W-1:0] pe_sum;
    logic                acc_push;
    t_out_item           acc_item;

    // Clamp the polynomial count into [1, MAX_POLYS]
    always_comb begin
        if (r_poly_count == '0) begin
            k_eff = CFG_W'(1);
        end else if (r_poly_count > CFG_W'(MAX_POLYS)) begin
            k_eff = CFG_W'(MAX_POLYS);
        end else begin
            k_eff = r_poly_count;
        end
    end

    // Classify the incoming item
    assign in_range = (CFG_W'(i_in_data.poly_index) < k_eff) &&
                      ((PAIR_W + 1)'(i_in_data.pair_index) < (PAIR_W + 1)'(PAIR_COUNT));
    assign in_emit   = (CFG_W'(i_in_data.poly_index) == (k_eff - CFG_W'(1)));
    assign in_accept = i_in_valid && o_in_ready;
    assign in_prod   = in_accept && in_range && in_emit;
    assign out_xfer  = o_out_valid && i_out_ready;

    assign o_in_ready = (r_used < FIFO_CNT_W'(OUT_FIFO_DEPTH));

    always_comb begin
        n_s1_ctl.valid = in_accept && in_range;
        n_s1_ctl.first = (i_in_data.poly_index == '0);
        n_s1_ctl.emit  = in_emit;
        n_s1_ctl.pair  = i_in_data.pair_index;
    end

    // Configuration register and result credit counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly_count <= CFG_W'(POLY_COUNT_RESET);
            r_used       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_poly_count <= i_cfg_wdata;
            end
            r_used <= r_used + FIFO_CNT_W'(in_prod) - FIFO_CNT_W'(out_xfer);
        end
    end

    // Advance valid bits and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
            r_s2_ctl <= '0;
            r_s7_ctl <= '0;
            for (int i = 0; i < DLY; i++) begin
                r_d1_ctl[i] <= '0;
                r_d2_ctl[i] <= '0;
            end
        end else begin
            r_s1_ctl    <= n_s1_ctl;
            r_s2_ctl    <= r_s1_ctl;
            r_d1_ctl[0] <= r_s2_ctl;
            r_s7_ctl    <= r_d1_ctl[DLY-1];
            r_d2_ctl[0] <= r_s7_ctl;
            for (int i = 1; i < DLY; i++) begin
                r_d1_ctl[i] <= r_d1_ctl[i-1];
                r_d2_ctl[i] <= r_d2_ctl[i-1];
            end
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        r_s1_item <= i_in_data;

        r_s2_a1b1  <= PROD_W'(r_s1_item.s_odd) * PROD_W'(r_s1_item.u_odd);
        r_s2_a0b0  <= PROD_W'(r_s1_item.s_even) * PROD_W'(r_s1_item.u_even);
        r_s2_cross <= BAR_IN_W'(PROD_W'(r_s1_item.s_even) * PROD_W'(r_s1_item.u_odd)) +
                      BAR_IN_W'(PROD_W'(r_s1_item.s_odd) * PROD_W'(r_s1_item.u_even));
        r_s2_gamma <= GAMMA_TAB[r_s1_item.pair_index];

        r_d1_a0b0[0]  <= r_s2_a0b0;
        r_d1_gamma[0] <= r_s2_gamma;
        for (int i = 1; i < DLY; i++) begin
            r_d1_a0b0[i]  <= r_d1_a0b0[i-1];
            r_d1_gamma[i] <= r_d1_gamma[i-1];
        end

        r_s7_m    <= PROD_W'(a1b1_red) * PROD_W'(r_d1_gamma[DLY-1]);
        r_s7_a0b0 <= r_d1_a0b0[DLY-1];
        r_s7_po   <= po_red;

        r_d2_po[0] <= r_s7_po;
        for (int i = 1; i < DLY; i++) begin
            r_d2_po[i] <= r_d2_po[i-1];
        end
    end

    // Reduce s_odd*u_odd and the cross sum
    mkip_barrett u_bar_a1b1 (
        .i_clk (i_clk),
        .i_v   (BAR_IN_W'(r_s2_a1b1)),
        .o_r   (a1b1_red)
    );

    mkip_barrett u_bar_odd (
        .i_clk (i_clk),
        .i_v   (r_s2_cross),
        .o_r   (po_red)
    );

    // Reduce the even sum
    assign pe_sum = BAR_IN_W'(r_s7_a0b0) + BAR_IN_W'(r_s7_m);

    mkip_barrett u_bar_even (
        .i_clk (i_clk),
        .i_v   (pe_sum),
        .o_r   (pe_red)
    );

    mkip_accum #(
        .PAIR_COUNT (PAIR_COUNT)
    ) u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_d2_ctl[DLY-1]),
        .i_pe    (pe_red),
        .i_po    (r_d2_po[DLY-1]),
        .o_push  (acc_push),
        .o_item  (acc_item)
    );

    mkip_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (acc_push),
        .i_item  (acc_item),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_data)
    );

`ifndef SYNTHESIS
    // Owed results never exceed the queue size
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= FIFO_CNT_W'(OUT_FIFO_DEPTH))
        else $error("result credit count exceeds queue depth");

    // A shown result is always covered by a credit
    a_out_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_used != '0))
        else $error("result shown without an owed credit");

    // A transfer with no new producing item frees exactly one credit
    a_credit_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && !in_prod) |=> (r_used == $past(r_used) - FIFO_CNT_W'(1)))
        else $error("credit not released on output transfer");

    // The end-of-polynomial flag agrees with the pair position
    a_last_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.last_pair ==
            ({1'b0, o_out_data.out_pair_index} == (PAIR_W + 1)'(PAIR_COUNT - 1))))
        else $error("last_pair flag disagrees with pair index");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/mkip_barrett.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mkip_barrett: four-stage Barrett reduction modulo q
// Reduces a 25-bit value with two reciprocal steps and one final conditional
// subtract; one constant multiply per stage.
// ----------------------------------------------------------------------------
module mkip_barrett (
    input  wire logic                          i_clk,
    input  wire logic [mkip_pkg::BAR_IN_W-1:0] i_v,
    output logic      [mkip_pkg::COEF_W-1:0]   o_r
);
    import mkip_pkg::*;

    logic [BAR_P1_W-1:0]  prod1;
    logic [BAR_IN_W-1:0]  t1q;
    logic [BAR_IN_W-1:0]  x1_full;
    logic [BAR_P2_W-1:0]  prod2;
    logic [BAR_X1_W:0]    t2q_full;
    logic [BAR_X1_W-1:0]  x2;
    logic [BAR_X1_W-1:0]  x3;

    logic [BAR_IN_W-1:0]  r_st1_v;
    logic [BAR_T1_W-1:0]  r_st1_t1;
    logic [BAR_X1_W-1:0]  r_st2_x1;
    logic [BAR_X1_W-1:0]  r_st3_x1;
    logic [BAR_T2_W-1:0]  r_st3_t2;
    logic [COEF_W-1:0]    r_res;

    // Stage 1: first quotient estimate
    assign prod1 = BAR_P1_W'(i_v) * BAR_P1_W'(BAR_M1);

    // Stage 2: first remainder, below about a hundred times q
    assign t1q     = BAR_IN_W'(r_st1_t1) * BAR_IN_W'(MOD_Q);
    assign x1_full = r_st1_v - t1q;

    // Stage 3: second quotient estimate
    assign prod2 = BAR_P2_W'(r_st2_x1) * BAR_P2_W'(BAR_M2);

    // Stage 4: second remainder, below 2q, then one conditional subtract
    assign t2q_full = (BAR_X1_W + 1)'(r_st3_t2) * (BAR_X1_W + 1)'(MOD_Q);
    assign x2       = r_st3_x1 - t2q_full[BAR_X1_W-1:0];
    assign x3       = (x2 >= BAR_X1_W'(MOD_Q)) ? (x2 - BAR_X1_W'(MOD_Q)) : x2;

    always_ff @(posedge i_clk) begin
        r_st1_v  <= i_v;
        r_st1_t1 <= prod1[BAR_P1_W-1:BAR_S1];
        r_st2_x1 <= x1_full[BAR_X1_W-1:0];
        r_st3_x1 <= r_st2_x1;
        r_st3_t2 <= prod2[BAR_P2_W-1:BAR_S2];
        r_res    <= x3[COEF_W-1:0];
    end

    assign o_r = r_res;

endmodule
`default_nettype wire

@@ hw/rtl/mkip_accum.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mkip_accum: per-pair accumulator and final reduction
// Holds one 28-bit sum per pair in a memory with registered read, forwards the
// sum written in the previous cycle, and reduces emitted sums into [0,q).
// ----------------------------------------------------------------------------
module mkip_accum #(
    parameter int PAIR_COUNT = mkip_pkg::PAIR_COUNT_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire mkip_pkg::t_acc_ctl          i_ctl,
    input  wire logic [mkip_pkg::COEF_W-1:0] i_pe,
    input  wire logic [mkip_pkg::COEF_W-1:0] i_po,
    output logic                             o_push,
    output mkip_pkg::t_out_item              o_item
);
    import mkip_pkg::*;

    localparam int ADDR_W = (PAIR_COUNT > 1) ? $clog2(PAIR_COUNT) : 1;

    localparam logic [HALF_W-1:0] Q1 = HALF_W'(MOD_Q);
    localparam logic [HALF_W-1:0] Q2 = HALF_W'(2 * MOD_Q);
    localparam logic [HALF_W-1:0] Q3 = HALF_W'(3 * MOD_Q);
    localparam logic [HALF_W-1:0] Q4 = HALF_W'(4 * MOD_Q);

    // Reduce a 14-bit sum (below 5q) into [0,q)
    function automatic logic [COEF_W-1:0] reduce_half(input logic [HALF_W-1:0] v);
        logic [HALF_W-1:0] r;
        if (v >= Q4) begin
            r = v - Q4;
        end else if (v >= Q3) begin
            r = v - Q3;
        end else if (v >= Q2) begin
            r = v - Q2;
        end else if (v >= Q1) begin
            r = v - Q1;
        end else begin
            r = v;
        end
        return r[COEF_W-1:0];
    endfunction

    logic [ACC_W-1:0]  r_acc_mem [PAIR_COUNT];
    logic [ACC_W-1:0]  r_rd;
    logic              r_byp_hit;
    logic [ACC_W-1:0]  r_byp_data;
    t_acc_ctl          r_s12_ctl;
    logic [COEF_W-1:0] r_s12_pe;
    logic [COEF_W-1:0] r_s12_po;
    logic              r_s13_valid;
    logic [HALF_W-1:0] r_s13_even;
    logic [HALF_W-1:0] r_s13_odd;
    logic [PAIR_W-1:0] r_s13_pair;

    logic [ACC_W-1:0]  acc_old;
    logic [HALF_W-1:0] n_even;
    logic [HALF_W-1:0] n_odd;
    logic [ACC_W-1:0]  n_sum;
    logic              n_byp_hit;

    // Take the sum written in the previous cycle when the memory read missed it
    assign acc_old = r_byp_hit ? r_byp_data : r_rd;

    // Overwrite on the first polynomial, otherwise add with 14-bit wrap
    always_comb begin
        if (r_s12_ctl.first) begin
            n_even = HALF_W'(r_s12_pe);
            n_odd  = HALF_W'(r_s12_po);
        end else begin
            n_even = acc_old[HALF_W-1:0] + HALF_W'(r_s12_pe);
            n_odd  = acc_old[ACC_W-1:HALF_W] + HALF_W'(r_s12_po);
        end
    end

    assign n_sum     = {n_odd, n_even};
    assign n_byp_hit = r_s12_ctl.valid && i_ctl.valid && (r_s12_ctl.pair == i_ctl.pair);

    // Accumulator memory: write the new sum, read for the next item
    always_ff @(posedge i_clk) begin
        if (r_s12_ctl.valid) begin
            r_acc_mem[r_s12_ctl.pair[ADDR_W-1:0]] <= n_sum;
        end
        r_rd <= r_acc_mem[i_ctl.pair[ADDR_W-1:0]];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s12_ctl   <= '0;
            r_byp_hit   <= 1'b0;
            r_s13_valid <= 1'b0;
        end else begin
            r_s12_ctl   <= i_ctl;
            r_byp_hit   <= n_byp_hit;
            r_s13_valid <= r_s12_ctl.valid && r_s12_ctl.emit;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_byp_data <= n_sum;
        r_s12_pe   <= i_pe;
        r_s12_po   <= i_po;
        r_s13_even <= n_even;
        r_s13_odd  <= n_odd;
        r_s13_pair <= r_s12_ctl.pair;
    end

    assign o_push                = r_s13_valid;
    assign o_item.w_even         = reduce_half(r_s13_even);
    assign o_item.w_odd          = reduce_half(r_s13_odd);
    assign o_item.out_pair_index = r_s13_pair;
    assign o_item.last_pair      = ({1'b0, r_s13_pair} == (PAIR_W + 1)'(PAIR_COUNT - 1));

endmodule
`default_nettype wire

@@ hw/rtl/mkip_out_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mkip_out_fifo: result queue at the output port
// Catches every result leaving the pipeline and presents them in order on a
// valid/ready channel; space is reserved upstream, so a push never overflows.
// ----------------------------------------------------------------------------
module mkip_out_fifo (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire mkip_pkg::t_out_item i_item,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output mkip_pkg::t_out_item      o_item
);
    import mkip_pkg::*;

    t_out_item             r_mem [OUT_FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_ready;
    assign o_item  = r_mem[r_rd_ptr];

    // Store a result
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + FIFO_CNT_W'(i_push) - FIFO_CNT_W'(pop);
        end
    end

endmodule
`default_nettype wire

@@ sim/mlkem_ntt_inner_product_unit_tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mlkem_ntt_inner_product_unit_tb: self-checking bench of the NTT inner product
// Streams coefficient pairs through the unit under random idling on both
// channels and scores every result against a pair-accumulating model that
// tracks the polynomial count register. A short directed table runs first,
// followed by phases of random vectors, each at its own polynomial count.
// ----------------------------------------------------------------------------
module mlkem_ntt_inner_product_unit_tb;

    import mkip_pkg::*;

    localparam int unsigned Q            = MOD_Q;
    localparam int          PAIRS        = PAIR_COUNT_DEF;
    localparam int          DRAIN_CYCLES = 24;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          PHASE_ITEMS  = 120;

    // Directed table row: the item, plus a typed result where one is obvious
    typedef struct {
        t_in_item  item;
        bit        known;
        t_out_item want;
    } t_row;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic [CFG_W-1:0] i_cfg_wdata;
    logic            i_in_valid;
    logic            o_in_ready;
    t_in_item        i_in_data;
    logic            o_out_valid;
    logic            i_out_ready;
    t_out_item       o_out_data;

    // Model state: register copy, twiddle table and per-pair sums
    logic [CFG_W-1:0]  poly_reg;
    int unsigned       twiddle_rom [PAIRS];
    logic [ACC_W-1:0]  pair_sum [PAIRS];
    bit                seeded [PAIRS];
    t_out_item         owed_results [$];
    t_row              directed_rows [$];

    int  error_count;
    int  items_taken;
    int  ignored_taken;
    int  results_seen;
    int  cfg_writes;
    bit  hold_req;
    bit  hold_done;
    bit  src_steady;
    bit  sink_steady;

    mlkem_ntt_inner_product_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // 10-unit clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Abort a hung run
    initial begin
        #10_000_000;
        $display("mlkem_ntt_inner_product_unit_tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------

    // Two-step Barrett reduction followed by one conditional subtract
    function automatic int unsigned barrett_q(int unsigned v);
        longint unsigned t;
        int unsigned     x;
        t = (longint'(v) * BAR_M1) >> BAR_S1;
        x = v - 32'(t) * Q;
        t = (longint'(x) * BAR_M2) >> BAR_S2;
        x = x - 32'(t) * Q;
        if (x >= Q) x = x - Q;
        return x;
    endfunction

    // 17^(2*bitrev7(idx)+1) mod q by square and multiply
    function automatic int unsigned twiddle_of(int idx);
        int unsigned rev;
        int unsigned e;
        int unsigned base;
        int unsigned r;
        rev = 0;
        for (int b = 0; b < PAIR_W; b++) begin
            rev = (rev << 1) | ((idx >> b) & 1);
        end
        e    = 2 * rev + 1;
        base = 17;
        r    = 1;
        while (e != 0) begin
            if (e[0]) r = (r * base) % Q;
            base = (base * base) % Q;
            e    = e >> 1;
        end
        return r;
    endfunction

    function automatic int poly_limit();
        if (poly_reg == 0) return 1;
        if (poly_reg > MAX_POLYS_DEF) return MAX_POLYS_DEF;
        return int'(poly_reg);
    endfunction

    // Advance the pair sums by one item; return 1 when it completes a vector
    function automatic bit predict_pair_sum(t_in_item it, output t_out_item res);
        int unsigned     a0, a1, b0, b1, odd_prod, pe, po;
        logic [HALF_W-1:0] se, so;
        int              k;
        k   = poly_limit();
        res = '0;
        if (int'(it.poly_index) >= k) return 1'b0;
        a0 = it.s_even;
        a1 = it.s_odd;
        b0 = it.u_even;
        b1 = it.u_odd;
        odd_prod = barrett_q(a1 * b1);
        pe = barrett_q(a0 * b0 + odd_prod * twiddle_rom[it.pair_index]);
        po = barrett_q(a0 * b1 + a1 * b0);
        if (it.poly_index == 0) begin
            se = HALF_W'(pe);
            so = HALF_W'(po);
        end else begin
            se = pair_sum[it.pair_index][HALF_W-1:0] + HALF_W'(pe);
            so = pair_sum[it.pair_index][ACC_W-1:HALF_W] + HALF_W'(po);
        end
        pair_sum[it.pair_index] = {so, se};
        if (int'(it.poly_index) != k - 1) return 1'b0;
        res.w_even         = COEF_W'(int'(se) % Q);
        res.w_odd          = COEF_W'(int'(so) % Q);
        res.out_pair_index = it.pair_index;
        res.last_pair      = (it.pair_index == PAIR_W'(PAIRS - 1));
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------------

    // Mostly short gaps, a few long ones
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [COEF_W-1:0] random_coef();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return COEF_W'($urandom_range(0, Q - 1));
        if (r < 90) return COEF_W'(Q - 1);
        if (r < 93) return '0;
        if (r < 95) return '1;
        return COEF_W'($urandom);
    endfunction

    function automatic t_in_item make_item(int pair, int poly);
        t_in_item it;
        it.s_even     = random_coef();
        it.s_odd      = random_coef();
        it.u_even     = random_coef();
        it.u_odd      = random_coef();
        it.pair_index = PAIR_W'(pair);
        it.poly_index = POLY_W'(poly);
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d (result %0d)",
                 what, got, want, results_seen);
        error_count++;
    endtask

    // Predict, then offer one item and hold it until transfer
    task automatic issue_item(t_in_item it, bit use_typed, t_out_item typed);
        t_out_item res;
        bit        has;
        int        gap;
        if (int'(it.poly_index) >= poly_limit()) ignored_taken++;
        has = predict_pair_sum(it, res);
        if (has) owed_results.push_back(use_typed ? typed : res);
        if (it.poly_index == 0) seeded[it.pair_index] = 1'b1;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
        items_taken++;
        gap = src_steady ? 0 : random_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic issue_random(int pair, int poly);
        issue_item(make_item(pair, poly), 1'b0, '0);
    endtask

    // Drop valid and wait until every owed result is back and the pipe is empty
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_poly_count(int value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= CFG_W'(value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        poly_reg     = CFG_W'(value);
        cfg_writes++;
    endtask

    task automatic add_row(int se, int so, int ue, int uo, int pair, int poly,
                           bit known, int we, int wo);
        t_row row;
        row.item.s_even          = COEF_W'(se);
        row.item.s_odd           = COEF_W'(so);
        row.item.u_even          = COEF_W'(ue);
        row.item.u_odd           = COEF_W'(uo);
        row.item.pair_index      = PAIR_W'(pair);
        row.item.poly_index      = POLY_W'(poly);
        row.known                = known;
        row.want.w_even          = COEF_W'(we);
        row.want.w_odd           = COEF_W'(wo);
        row.want.out_pair_index  = PAIR_W'(pair);
        row.want.last_pair       = (pair == PAIRS - 1);
        directed_rows.push_back(row);
    endtask

    // One phase of random traffic at the current polynomial count
    task automatic run_phase(int target, bit pause_midway);
        int k;
        int made;
        int sel;
        int n;
        int pair;
        int poly;
        bit paused;
        int pairs [$];
        k      = poly_limit();
        made   = 0;
        paused = 1'b0;
        while (made < target) begin
            sel = $urandom_range(0, 99);
            if (pause_midway && !paused && made >= target / 2) begin
                wait_idle();
                paused = 1'b1;
            end
            if (sel < 70) begin
                // Well-formed vector over a set of pairs, poly 0 first
                pairs.delete();
                n = ($urandom_range(0, 39) == 0) ? PAIRS : $urandom_range(1, 12);
                for (int i = 0; i < n; i++) begin
                    pairs.push_back((n == PAIRS) ? i : $urandom_range(0, PAIRS - 1));
                end
                if ($urandom_range(0, 1) == 0) begin
                    foreach (pairs[i]) begin
                        for (int p = 0; p < k; p++) issue_random(pairs[i], p);
                    end
                end else begin
                    for (int p = 0; p < k; p++) begin
                        foreach (pairs[i]) issue_random(pairs[i], p);
                    end
                end
                made += n * k;
            end else if (sel < 85) begin
                // Broken sequence: a lone polynomial on some pair
                pair = $urandom_range(0, PAIRS - 1);
                poly = 0;
                if (seeded[pair] && $urandom_range(0, 1) == 1) poly = $urandom_range(0, k - 1);
                issue_random(pair, poly);
                made++;
            end else if (k < MAX_POLYS_DEF) begin
                // Polynomial index beyond the count: dropped by the block
                issue_random($urandom_range(0, PAIRS - 1), $urandom_range(k, 3));
            end else begin
                pair = $urandom_range(0, PAIRS - 1);
                issue_random(pair, seeded[pair] ? $urandom_range(0, 3) : 0);
                made++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: ready pattern and result scoring
    // ------------------------------------------------------------------------

    // Randomize ready; on request hold it low for a long stretch
    initial begin
        int run_left;
        run_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                for (int c = 0; c < HOLD_CYCLES; c++) @(posedge i_clk);
                hold_req  = 1'b0;
                hold_done = 1'b1;
                run_left  = 0;
            end else if (sink_steady) begin
                i_out_ready <= 1'b1;
            end else if (run_left > 0) begin
                run_left--;
            end else if ($urandom_range(0, 2) == 0) begin
                i_out_ready <= 1'b0;
                run_left     = random_gap();
            end else begin
                i_out_ready <= 1'b1;
                run_left     = $urandom_range(0, 12);
            end
        end
    end

    // Inputs only move at rising edges, so the falling edge sees the transfer
    always @(negedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (owed_results.size() == 0) begin
                report_mismatch("unexpected result, pair", int'(o_out_data.out_pair_index),
                                -1);
            end else begin
                want = owed_results.pop_front();
                if (o_out_data.w_even !== want.w_even)
                    report_mismatch("w_even", o_out_data.w_even, want.w_even);
                if (o_out_data.w_odd !== want.w_odd)
                    report_mismatch("w_odd", o_out_data.w_odd, want.w_odd);
                if (o_out_data.out_pair_index !== want.out_pair_index)
                    report_mismatch("out_pair_index", o_out_data.out_pair_index,
                                    want.out_pair_index);
                if (o_out_data.last_pair !== want.last_pair)
                    report_mismatch("last_pair", o_out_data.last_pair, want.last_pair);
            end
            results_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int phase_counts [12];
        phase_counts  = '{1, 4, 0, 7, 2, 5, 3, 6, 4, 2, 1, 3};
        error_count   = 0;
        items_taken   = 0;
        ignored_taken = 0;
        results_seen  = 0;
        cfg_writes    = 0;
        hold_req      = 1'b0;
        hold_done     = 1'b0;
        src_steady    = 1'b0;
        sink_steady   = 1'b0;
        poly_reg      = CFG_W'(POLY_COUNT_RESET);
        for (int i = 0; i < PAIRS; i++) begin
            twiddle_rom[i] = twiddle_of(i);
            pair_sum[i]    = '0;
            seeded[i]      = 1'b0;
        end
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table at the reset count of three polynomials
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, 0, 0, 1, 0, 0, 0);
        add_row(0, 0, 0, 0, 0, 2, 1, 0, 0);
        add_row(1, 0, 1, 0, 5, 0, 0, 0, 0);
        add_row(0, 0, 0, 0, 5, 1, 0, 0, 0);
        add_row(0, 0, 0, 0, 5, 2, 1, 1, 0);
        add_row(1, 0, 0, 1, 9, 0, 0, 0, 0);
        add_row(0, 0, 0, 0, 9, 1, 0, 0, 0);
        add_row(0, 0, 0, 0, 9, 2, 1, 0, 1);
        add_row(4095, 4095, 4095, 4095, 127, 0, 0, 0, 0);
        add_row(4095, 4095, 4095, 4095, 127, 1, 0, 0, 0);
        add_row(4095, 4095, 4095, 4095, 127, 2, 0, 0, 0);
        add_row(3328, 3328, 3328, 3328, 64, 0, 0, 0, 0);
        add_row(3328, 3328, 3328, 3328, 64, 1, 0, 0, 0);
        add_row(3328, 3328, 3328, 3328, 64, 2, 0, 0, 0);
        add_row(1, 2, 3, 4, 127, 3, 0, 0, 0);
        add_row(0, 3328, 0, 3328, 1, 0, 0, 0, 0);
        add_row(0, 0, 0, 0, 1, 1, 0, 0, 0);
        add_row(0, 0, 0, 0, 1, 2, 0, 0, 0);
        add_row(5, 6, 7, 8, 0, 2, 0, 0, 0);
        add_row(0, 0, 0, 0, 127, 0, 0, 0, 0);
        add_row(0, 0, 0, 0, 127, 1, 0, 0, 0);
        add_row(0, 0, 0, 0, 127, 2, 1, 0, 0);
        foreach (directed_rows[i]) begin
            issue_item(directed_rows[i].item, directed_rows[i].known,
                       directed_rows[i].want);
        end

        // Random phases, each at its own polynomial count
        foreach (phase_counts[i]) begin
            write_poly_count(phase_counts[i]);
            src_steady  = (i % 4 == 3) || (i == 0);
            sink_steady = (i % 4 == 1);
            if (i == 0) hold_req = 1'b1;
            run_phase(PHASE_ITEMS, i == 2);
        end

        // Drain and report
        wait_idle();
        $display("Covered %0d transfers in (%0d dropped), %0d results scored, %0d count writes,",
                 items_taken, ignored_taken, results_seen, cfg_writes);
        $display("counts 0..7 with clamping, extreme coefficients and a %0d-cycle output stall%s.",
                 HOLD_CYCLES, hold_done ? "" : " (not reached)");
        if (error_count == 0) begin
            $display("mlkem_ntt_inner_product_unit_tb: done, clean");
        end else begin
            $display("mlkem_ntt_inner_product_unit_tb: done, errors");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ mlkem_ntt_inner_product_unit.f @@
hw/rtl/mkip_pkg.sv
hw/rtl/mkip_barrett.sv
hw/rtl/mkip_accum.sv
hw/rtl/mkip_out_fifo.sv
hw/rtl/mlkem_ntt_inner_product_unit.sv
sim/mlkem_ntt_inner_product_unit_tb.sv
